/* rtl/tpcd_pkg.sv */
// Package of the TDC packet channel decoder: sizes, field codes and the
// structs passed between the parser, the channel store and the top level.
// No dependencies.
`default_nettype none

package tpcd_pkg;

  localparam int NumModules      = 12;
  localparam int NumChannels     = NumModules * 32;
  localparam int NumPairs        = NumChannels / 2;
  localparam int PairAw          = $clog2(NumPairs);
  localparam int MaxWordsDefault = 1024;

  localparam int TdcW   = 6;
  localparam int TrigW  = 2;
  localparam int PairDw = 2 * TdcW + TrigW;

  localparam logic [TdcW-1:0] EmptyTdc = 6'd43;

  // Header tags.
  localparam logic [3:0] TagModule = 4'd4;
  localparam logic [3:0] TagEvent  = 4'd5;
  localparam logic [3:0] TagClock  = 4'd6;

  // Range of FPGA positions that carry channel data.
  localparam logic [5:0] PosFirst = 6'd6;
  localparam logic [5:0] PosLast  = 6'd17;

  typedef struct packed {
    logic              en;
    logic [PairAw-1:0] addr;
    logic [PairDw-1:0] data;
  } wr_cmd_t;

  typedef struct packed {
    logic        pkt_valid;
    logic [11:0] module_addr;
    logic [11:0] event_num;
    logic [11:0] clock_count;
    logic [15:0] parity;
    logic [1:0]  flags;
  } hdr_t;

endpackage

`default_nettype wire

/* rtl/tpcd_store.sv */
// Channel store: one synchronous memory entry per channel pair plus a
// written mark per pair in flip-flops. Depends on tpcd_pkg.
`default_nettype none

module tpcd_store (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           clear_i,
  input  wire tpcd_pkg::wr_cmd_t              wr_i,
  input  wire logic                           rd_en_i,
  input  wire logic [tpcd_pkg::PairAw-1:0]    rd_addr_i,
  output logic      [tpcd_pkg::PairDw-1:0]    rd_data_o,
  output logic                                rd_written_o
);

  logic [tpcd_pkg::PairDw-1:0]   mem [tpcd_pkg::NumPairs];
  logic [tpcd_pkg::NumPairs-1:0] written_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  // The marks are cleared at once when a packet starts, so the memory
  // itself never needs a clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_o <= 1'b0;
    end else begin
      if (clear_i) begin
        written_q <= '0;
      end else if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_o <= written_q[rd_addr_i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tpcd_parser.sv */
// Packet word parser: tracks the word index, decodes header and trailer
// fields and issues pair writes for data words. Depends on tpcd_pkg.
`default_nettype none

module tpcd_parser #(
  parameter int MAX_WORDS = tpcd_pkg::MaxWordsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              word_en_i,
  input  wire logic [31:0]       word_i,
  input  wire logic              last_i,
  output logic                   clear_o,
  output tpcd_pkg::wr_cmd_t      wr_o,
  output tpcd_pkg::hdr_t         hdr_o
);

  localparam int IdxW = $clog2(MAX_WORDS);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_WORDS - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            hok_q, hok_d;
  tpcd_pkg::hdr_t  hdr_q, hdr_d;

  logic            first_word;
  logic            hok_eff;
  logic [5:0]      pos;
  logic            pos_ok;
  logic [5:0]      module_num;

  assign first_word = (idx_q == '0);
  assign hok_eff    = first_word ? word_i[30] : hok_q;
  assign pos        = word_i[26:21];
  assign pos_ok     = (pos >= tpcd_pkg::PosFirst) && (pos <= tpcd_pkg::PosLast);
  // Positions 17 down to 6 map two by two onto modules 0 to 5.
  assign module_num = (tpcd_pkg::PosLast - pos) >> 1;

  always_comb begin
    idx_d   = idx_q;
    hok_d   = hok_q;
    hdr_d   = hdr_q;
    clear_o = 1'b0;
    wr_o    = '0;
    if (word_en_i) begin
      if (first_word) begin
        clear_o = 1'b1;
        hdr_d   = '0;
        hok_d   = word_i[30];
      end
      if (hok_eff && (idx_q < IdxW'(3)) && word_i[29]) begin
        case (word_i[15:12])
          tpcd_pkg::TagModule: hdr_d.module_addr = word_i[11:0];
          tpcd_pkg::TagEvent:  hdr_d.event_num   = word_i[11:0];
          tpcd_pkg::TagClock:  hdr_d.clock_count = word_i[11:0];
          default: ;
        endcase
      end
      if (last_i) begin
        if (word_i[31] && (idx_q >= IdxW'(2))) begin
          hdr_d.pkt_valid = 1'b1;
          hdr_d.parity    = word_i[27:12];
          hdr_d.flags     = word_i[1:0];
        end
        idx_d = '0;
      end else begin
        if (hok_q && (idx_q >= IdxW'(3)) && pos_ok) begin
          wr_o.en   = 1'b1;
          wr_o.addr = {module_num[2:0], word_i[20:16]};
          wr_o.data = {word_i[13:12], word_i[11:6], word_i[5:0]};
        end
        if (idx_q != IdxMax) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hok_q <= 1'b0;
      hdr_q <= '0;
    end else begin
      idx_q <= idx_d;
      hok_q <= hok_d;
      hdr_q <= hdr_d;
    end
  end

  assign hdr_o = hdr_q;

endmodule

`default_nettype wire

/* rtl/tdc_packet_channel_decoder_unit.sv */
// TDC packet channel decoder, top level: input handshake, read sequencing
// and the output register. Depends on tpcd_pkg, tpcd_parser, tpcd_store.
//
// One input channel carries two kinds of beat. A packet word beat
// (kind_i = 0) feeds the parser; the beat with last_i set is the trailer.
// A channel read beat (kind_i = 1) returns one result beat with the
// channel's TDC value and trigger bits and the header and trailer fields
// of the most recent packet. Packet words produce no result.
// Packet words are taken one per cycle while no read is pending. A read
// goes through the registered pair memory, and input is stalled while the
// read data is pending. The result is loaded into the output register
// from the pending stage once that register is free.
// When the receiver stalls, the result holds in the output register and
// packet words keep flowing; a further read is accepted and then stalls
// input until the register is free. Reset clears the word index, the
// header and trailer fields and the per-pair written marks; the pair
// memory needs no clearing pass.
`default_nettype none

module tdc_packet_channel_decoder_unit #(
  parameter int MAX_WORDS = tpcd_pkg::MaxWordsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] word_i,
  input  wire logic        last_i,
  input  wire logic [8:0]  channel_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       tdc_o,
  output logic [1:0]       trig_o,
  output logic             decoded_ok_o,
  output logic [11:0]      event_number_o,
  output logic [11:0]      clock_count_o,
  output logic [11:0]      module_address_o,
  output logic [15:0]      parity_word_o,
  output logic             parity_ok_o,
  output logic             event_match_o
);

  logic                          in_acc;
  logic                          word_acc;
  logic                          rd_acc;
  logic                          ch_in_range;
  logic                          clear;
  tpcd_pkg::wr_cmd_t             wr;
  tpcd_pkg::hdr_t                hdr;
  logic [tpcd_pkg::PairDw-1:0]   rd_data;
  logic                          rd_written;

  logic pend_q;
  logic in_range_q;
  logic ch_lsb_q;
  logic slot_free;
  logic load;
  logic out_valid_q, out_valid_d;

  assign in_stall_o  = pend_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign word_acc    = in_acc && !kind_i;
  assign rd_acc      = in_acc && kind_i;
  assign ch_in_range = (channel_i < 9'(tpcd_pkg::NumChannels));

  tpcd_parser #(
    .MAX_WORDS (MAX_WORDS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_en_i (word_acc),
    .word_i    (word_i),
    .last_i    (last_i),
    .clear_o   (clear),
    .wr_o      (wr),
    .hdr_o     (hdr)
  );

  tpcd_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .wr_i         (wr),
    .rd_en_i      (rd_acc && ch_in_range),
    .rd_addr_i    (channel_i[8:1]),
    .rd_data_o    (rd_data),
    .rd_written_o (rd_written)
  );

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      in_range_q <= ch_in_range;
      ch_lsb_q   <= channel_i[0];
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign load      = pend_q && slot_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_acc) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Header and trailer state cannot change while a read is pending, since
  // input is stalled, so it is taken live when the result is loaded.
  always_ff @(posedge clk_i) begin
    if (load) begin
      decoded_ok_o     <= hdr.pkt_valid;
      event_number_o   <= hdr.pkt_valid ? hdr.event_num   : 12'd0;
      clock_count_o    <= hdr.pkt_valid ? hdr.clock_count : 12'd0;
      module_address_o <= hdr.pkt_valid ? hdr.module_addr : 12'd0;
      parity_word_o    <= hdr.pkt_valid ? hdr.parity      : 16'd0;
      parity_ok_o      <= hdr.pkt_valid && hdr.flags[0];
      event_match_o    <= hdr.pkt_valid && hdr.flags[1];
      if (hdr.pkt_valid && in_range_q && rd_written) begin
        tdc_o  <= ch_lsb_q ? rd_data[11:6] : rd_data[5:0];
        trig_o <= rd_data[13:12];
      end else if (hdr.pkt_valid && in_range_q) begin
        tdc_o  <= tpcd_pkg::EmptyTdc;
        trig_o <= '0;
      end else begin
        tdc_o  <= '0;
        trig_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_read_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> pend_q)
    else $error("accepted read did not enter the pending stage");

  a_pend_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && slot_free) |=> (out_valid_q && !pend_q))
    else $error("pending read was not moved into the output register");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result appeared without a pending read");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !decoded_ok_o) |->
      (tdc_o == '0 && trig_o == '0 && module_address_o == '0 && parity_word_o == '0))
    else $error("result of an invalid packet is not all zeros");

endmodule

`default_nettype wire

/* verif/tdc_packet_channel_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the TDC packet channel decoder: directed table, then random packets.
// Uses tpcd_pkg and the top level tdc_packet_channel_decoder_unit; a predictor or a typed row checks every read.

module tdc_packet_channel_decoder_unit_tb;

  localparam bit KindWord     = 1'b0;
  localparam bit KindRead     = 1'b1;
  localparam int MaxWords     = tpcd_pkg::MaxWordsDefault;
  localparam int ModuleStride = 64;
  localparam int QuietLimit   = 2000;
  localparam int NumDirRows   = 25;
  localparam int PhaseBeats   = 40;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic        last;
    logic [8:0]  channel;
  } beat_t;

  typedef struct packed {
    logic [5:0]  tdc;
    logic [1:0]  trig;
    logic        decoded_ok;
    logic [11:0] event_number;
    logic [11:0] clock_count;
    logic [11:0] module_address;
    logic [15:0] parity_word;
    logic        parity_ok;
    logic        event_match;
  } read_res_t;

  typedef struct packed {
    beat_t     b;
    logic      typed;
    read_res_t res;
  } row_t;

  // Fields of the first directed packet, as seen by a read.
  localparam read_res_t ResAEmpty =
    '{6'd43, 2'd0, 1'b1, 12'hABC, 12'h123, 12'hFFF, 16'hFFFF, 1'b1, 1'b1};
  localparam read_res_t ResAHigh =
    '{6'd0, 2'd0, 1'b1, 12'hABC, 12'h123, 12'hFFF, 16'hFFFF, 1'b1, 1'b1};
  localparam read_res_t ResZero = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = KindWord;
  logic [31:0] word_i = '0;
  logic        last_i = 1'b0;
  logic [8:0]  channel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  tdc_o;
  logic [1:0]  trig_o;
  logic        decoded_ok_o;
  logic [11:0] event_number_o;
  logic [11:0] clock_count_o;
  logic [11:0] module_address_o;
  logic [15:0] parity_word_o;
  logic        parity_ok_o;
  logic        event_match_o;

  tdc_packet_channel_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .word_i          (word_i),
    .last_i          (last_i),
    .channel_i       (channel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tdc_o           (tdc_o),
    .trig_o          (trig_o),
    .decoded_ok_o    (decoded_ok_o),
    .event_number_o  (event_number_o),
    .clock_count_o   (clock_count_o),
    .module_address_o(module_address_o),
    .parity_word_o   (parity_word_o),
    .parity_ok_o     (parity_ok_o),
    .event_match_o   (event_match_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decoder state as predicted from the accepted beats.
  logic [tpcd_pkg::TdcW-1:0]  tdc_mem [tpcd_pkg::NumChannels];
  logic [tpcd_pkg::TrigW-1:0] trig_mem [tpcd_pkg::NumChannels];
  bit                         chan_written [tpcd_pkg::NumChannels];
  int unsigned      word_idx;
  bit               hdr_present;
  logic [11:0]      hdr_module, hdr_event, hdr_clock;
  logic [15:0]      trl_parity;
  logic [1:0]       trl_flags;
  bit               pkt_valid;

  read_res_t   expected_reads [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  row_t        dir_rows [NumDirRows];

  // Applies one accepted beat; returns 1 with the read result for a channel read.
  function automatic bit decode_beat(input beat_t b, output read_res_t r);
    int unsigned pos, base;
    r = '0;
    if (b.kind == KindWord) begin
      if (word_idx == 0) begin
        foreach (chan_written[i]) chan_written[i] = 1'b0;
        hdr_present = b.word[30];
        hdr_module = '0;
        hdr_event = '0;
        hdr_clock = '0;
        trl_parity = '0;
        trl_flags = '0;
        pkt_valid = 1'b0;
      end
      if (hdr_present && word_idx < 3 && b.word[29]) begin
        case (b.word[15:12])
          tpcd_pkg::TagModule: hdr_module = b.word[11:0];
          tpcd_pkg::TagEvent:  hdr_event = b.word[11:0];
          tpcd_pkg::TagClock:  hdr_clock = b.word[11:0];
          default: ;
        endcase
      end
      if (b.last) begin
        if (b.word[31] && word_idx >= 2) begin
          pkt_valid = 1'b1;
          trl_parity = b.word[27:12];
          trl_flags = b.word[1:0];
        end
        word_idx = 0;
      end else begin
        pos = b.word[26:21];
        if (hdr_present && word_idx >= 3 &&
            pos >= tpcd_pkg::PosFirst && pos <= tpcd_pkg::PosLast) begin
          // Positions run downward: the highest one feeds module 0.
          base = ((tpcd_pkg::PosLast - pos) / 2) * ModuleStride + 2 * b.word[20:16];
          tdc_mem[base] = b.word[5:0];
          tdc_mem[base+1] = b.word[11:6];
          trig_mem[base] = b.word[13:12];
          trig_mem[base+1] = b.word[13:12];
          chan_written[base] = 1'b1;
          chan_written[base+1] = 1'b1;
        end
        if (word_idx < MaxWords - 1) word_idx++;
      end
      return 1'b0;
    end
    if (pkt_valid) begin
      if (b.channel < tpcd_pkg::NumChannels) begin
        if (chan_written[b.channel]) begin
          r.tdc = tdc_mem[b.channel];
          r.trig = trig_mem[b.channel];
        end else begin
          r.tdc = tpcd_pkg::EmptyTdc;
        end
      end
      r.decoded_ok = 1'b1;
      r.event_number = hdr_event;
      r.clock_count = hdr_clock;
      r.module_address = hdr_module;
      r.parity_word = trl_parity;
      r.parity_ok = trl_flags[0];
      r.event_match = trl_flags[1];
    end
    return 1'b1;
  endfunction

  function automatic beat_t mk_word(input logic [31:0] w, input logic last);
    beat_t b;
    b.kind = KindWord;
    b.word = w;
    b.last = last;
    b.channel = 9'($urandom);
    return b;
  endfunction

  function automatic beat_t mk_read(input logic [8:0] ch);
    beat_t b;
    b.kind = KindRead;
    b.word = $urandom;
    b.last = 1'($urandom);
    b.channel = ch;
    return b;
  endfunction

  function automatic row_t row_word(input logic [31:0] w, input logic last);
    return '{mk_word(w, last), 1'b0, ResZero};
  endfunction

  function automatic row_t row_read(input logic [8:0] ch, input logic typed,
                                    input read_res_t res);
    return '{mk_read(ch), typed, res};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offers one beat, holds it until accepted, then records what it should cause.
  task automatic offer(input beat_t b, input logic typed = 1'b0,
                       input read_res_t typed_res = '0);
    read_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= b.kind;
    word_i <= b.word;
    last_i <= b.last;
    channel_i <= b.channel;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (decode_beat(b, r)) expected_reads.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_reads.size() != 0) @(posedge clk_i);
  endtask

  // About half of the reads make up to eight tries to aim at a channel written in the current packet.
  task automatic random_read();
    beat_t       b;
    int unsigned ch;
    b = mk_read(9'($urandom_range(511)));
    if ($urandom_range(1) == 1) begin
      for (int k = 0; k < 8; k++) begin
        ch = $urandom_range(tpcd_pkg::NumChannels - 1);
        if (chan_written[ch]) begin
          b.channel = 9'(ch);
          break;
        end
      end
    end
    offer(b);
  endtask

  task automatic random_packet(input int unsigned n_data);
    beat_t b;
    for (int k = 0; k < 3; k++) begin
      b = mk_word($urandom, 1'b0);
      if (k == 0) b.word[30] = ($urandom_range(9) != 0);
      if ($urandom_range(3) != 0) begin
        b.word[29] = 1'b1;
        b.word[15:12] = tpcd_pkg::TagModule + 4'($urandom_range(2));
      end
      offer(b);
    end
    for (int unsigned k = 0; k < n_data; k++) begin
      b = mk_word($urandom, 1'b0);
      if ($urandom_range(7) != 0) begin
        b.word[26:21] = tpcd_pkg::PosFirst + 6'($urandom_range(11));
      end
      offer(b);
      if ($urandom_range(19) == 0) random_read();
    end
    b = mk_word($urandom, 1'b1);
    b.word[31] = ($urandom_range(7) != 0);
    offer(b);
  endtask

  always @(posedge clk_i) begin : result_side
    read_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reads.size() == 0) begin
        $error("result beat with no read waiting");
        mismatch_count++;
      end else begin
        want = expected_reads.pop_front();
        check_field("tdc", want.tdc, tdc_o);
        check_field("trig", want.trig, trig_o);
        check_field("decoded_ok", want.decoded_ok, decoded_ok_o);
        check_field("event_number", want.event_number, event_number_o);
        check_field("clock_count", want.clock_count, clock_count_o);
        check_field("module_address", want.module_address, module_address_o);
        check_field("parity_word", want.parity_word, parity_word_o);
        check_field("parity_ok", want.parity_ok, parity_ok_o);
        check_field("event_match", want.event_match, event_match_o);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start, n;

    void'(decode_beat(mk_word(32'h0, 1'b1), dir_rows[0].res));
    word_idx = 0;
    pkt_valid = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      // Full header, data at both ends of the channel range, rejected positions.
      row_word(32'h6000_4FFF, 1'b0), row_word(32'h2000_5ABC, 1'b0),
      row_word(32'h2000_6123, 1'b0), row_word(32'h0220_3FC0, 1'b0),
      row_word(32'h00DF_003F, 1'b0), row_word(32'h00BF_FFFF, 1'b0),
      row_word(32'h07FF_FFFF, 1'b0), row_word(32'hFFFF_FFFF, 1'b1),
      row_read(9'd0, 1'b0, ResZero), row_read(9'd383, 1'b0, ResZero),
      row_read(9'd2, 1'b1, ResAEmpty), row_read(9'd511, 1'b1, ResAHigh),
      // Trailer too early, then a trailer without its marker bit.
      row_word(32'h0000_0000, 1'b0), row_word(32'h8000_0000, 1'b1),
      row_read(9'd5, 1'b1, ResZero),
      row_word(32'h4000_0000, 1'b0), row_word(32'h0000_0000, 1'b0),
      row_word(32'h7FFF_FFFF, 1'b1), row_read(9'd1, 1'b1, ResZero),
      // A trailer at index two that also carries a header value.
      row_word(32'h6000_4001, 1'b0), row_word(32'h0000_0000, 1'b0),
      row_word(32'hA000_6FFF, 1'b1), row_read(9'd100, 1'b0, ResZero),
      // A read while a packet is still open sees nothing.
      row_word(32'h4000_0000, 1'b0), row_read(9'd383, 1'b1, ResZero)
    };
    foreach (dir_rows[i]) offer(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      phase_start = beats_sent;
      if (phase == 0) begin
        // Runs past the word index ceiling before the trailer.
        random_packet(MaxWords + 6);
        random_read();
      end
      if (phase == 2) begin
        // The receiver holds off while reads pile up behind the output register.
        send_idle_pct = 0;
        random_packet(6);
        hold_req = 80;
        repeat (12) random_read();
        wait_drained();
        send_idle_pct = 0;
      end
      while (beats_sent - phase_start < PhaseBeats) begin
        n = $urandom_range(99);
        if (n < 60) begin
          random_packet(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8));
          repeat ($urandom_range(1, 4)) random_read();
        end else if (n < 80) begin
          repeat ($urandom_range(1, 6)) random_read();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            offer('{1'($urandom), 32'($urandom), 1'($urandom_range(3) == 0),
                    9'($urandom)});
          end
        end
      end
      if (phase == 1) wait_drained();
    end

    recv_stall_pct = 15;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
